FILE: rtl/core/fqd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the delete-by-value queue
package fqd_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_DROP   = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_PEEK   = 3'd3,
        MODE_CLEAR  = 3'd4
    } fqd_mode_t;

    typedef struct packed {
        logic              drop;
        logic              del;
        logic              app;
        logic [DATA_W-1:0] value;
    } fqd_cmd_t;

    typedef struct packed {
        logic live;
        logic tail;
    } fqd_cell_ctl_t;

endpackage

FILE: rtl/core/fifo_queue_delete_by_value.sv
`timescale 1ns / 1ps
// Bounded FIFO of signed 32-bit values with append, drop head, delete first match, peek and
// clear. Entries live in a row of cells, head in cell 0; every cell compares its entry against
// the beat's value at once and the first matching cell and all cells after it shift one place toward the head.
// One beat is taken per clock and its result appears in the output register on the next clock;
// the input stalls only while that register holds a result the output side is stalling.
// Append to a full queue leaves it unchanged and raises rejected.
module fifo_queue_delete_by_value #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  mode,
    input  logic signed [31:0]          value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        head_valid,
    output logic signed [31:0]          head_value,
    output logic [CNT_W-1:0]            occupancy,
    output logic                        found,
    output logic                        rejected
);

    logic                        accept;
    fqd_pkg::fqd_cmd_t           cmd;
    logic                        op_drop;
    logic                        op_del;
    logic                        op_app;
    logic                        op_clear;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        full;
    logic                        found_now;

    logic [fqd_pkg::DATA_W-1:0]  cell_data [QUEUE_DEPTH];
    logic [fqd_pkg::DATA_W-1:0]  cell_next [QUEUE_DEPTH];
    logic                        seen [QUEUE_DEPTH+1];

    logic                        out_valid_reg;
    logic                        head_valid_reg;
    logic [31:0]                 head_value_reg;
    logic [CNT_W-1:0]            occupancy_reg;
    logic                        found_reg;
    logic                        rejected_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        op_drop  = 1'b0;
        op_del   = 1'b0;
        op_app   = 1'b0;
        op_clear = 1'b0;
        unique case (fqd_pkg::fqd_mode_t'(mode))
            fqd_pkg::MODE_APPEND: op_app   = accept && !full;
            fqd_pkg::MODE_DROP:   op_drop  = accept;
            fqd_pkg::MODE_DELETE: op_del   = accept;
            fqd_pkg::MODE_CLEAR:  op_clear = accept;
            default:              ;
        endcase
    end

    assign cmd.drop  = op_drop;
    assign cmd.del   = op_del;
    assign cmd.app   = op_app;
    assign cmd.value = value;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        fqd_pkg::fqd_cell_ctl_t     ctl;
        logic [fqd_pkg::DATA_W-1:0] from_right;

        assign ctl.live = (CNT_W'(i) < count_reg);
        assign ctl.tail = (CNT_W'(i) == count_reg);

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign from_right = '0;
        end
        else
        begin : g_mid
            assign from_right = cell_data[i+1];
        end

        fqd_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .ctl       (ctl),
            .data_in   (from_right),
            .seen_in   (seen[i]),
            .data      (cell_data[i]),
            .data_next (cell_next[i]),
            .seen_out  (seen[i+1])
        );
    end

    assign found_now = op_del && seen[QUEUE_DEPTH];

    always_comb
    begin
        count_next = count_reg;
        priority if (op_clear)
        begin
            count_next = '0;
        end
        else if (op_app)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if ((op_drop && (count_reg != '0)) || found_now)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_valid_reg <= (count_next != '0);
            head_value_reg <= (count_next != '0) ? cell_next[0] : '0;
            occupancy_reg  <= count_next;
            found_reg      <= found_now;
            rejected_reg   <= (fqd_pkg::fqd_mode_t'(mode) == fqd_pkg::MODE_APPEND) && full;
        end
    end

    assign out_valid  = out_valid_reg;
    assign head_valid = head_valid_reg;
    assign head_value = head_value_reg;
    assign occupancy  = occupancy_reg;
    assign found      = found_reg;
    assign rejected   = rejected_reg;

endmodule

FILE: rtl/core/fqd_cell.sv
`timescale 1ns / 1ps
// one queue slot: holds an entry, matches it and shifts toward the head
module fqd_cell (
    input  logic                          clk,
    input  fqd_pkg::fqd_cmd_t             cmd,
    input  fqd_pkg::fqd_cell_ctl_t        ctl,
    input  logic [fqd_pkg::DATA_W-1:0]    data_in,
    input  logic                          seen_in,
    output logic [fqd_pkg::DATA_W-1:0]    data,
    output logic [fqd_pkg::DATA_W-1:0]    data_next,
    output logic                          seen_out
);

    logic [fqd_pkg::DATA_W-1:0] data_reg;
    logic                       hit;
    logic                       shift;

    assign hit      = ctl.live && (data_reg == cmd.value);
    assign seen_out = seen_in | hit;
    assign shift    = cmd.drop | (cmd.del & seen_out);

    always_comb
    begin
        priority if (shift)
        begin
            data_next = data_in;
        end
        else if (cmd.app && ctl.tail)
        begin
            data_next = cmd.value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: tb/fqd_checker.sv
`timescale 1ns / 1ps
// watches both channels of the delete-by-value queue, predicts each result and compares it
module fqd_checker #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               head_valid,
    input  logic signed [31:0] head_value,
    input  logic [CNT_W-1:0]   occupancy,
    input  logic               found,
    input  logic               rejected,
    output int                 mismatches,
    output int                 pending
);

    typedef struct packed {
        logic               hv;
        logic signed [31:0] hval;
        logic [CNT_W-1:0]   occ;
        logic               fnd;
        logic               rej;
    } queue_status_t;

    logic signed [31:0] held [$];
    queue_status_t      awaited [$];
    int                 fail_count = 0;
    int                 waiting = 0;

    assign mismatches = fail_count;
    assign pending    = waiting;

    function automatic queue_status_t apply_op(input logic [2:0] m, input logic signed [31:0] v);
        queue_status_t s;
        int            hit;
        s   = '0;
        hit = -1;
        case (m)
            fqd_pkg::MODE_APPEND:
                if (held.size() >= DEPTH)
                    s.rej = 1'b1;
                else
                    held.push_back(v);
            fqd_pkg::MODE_DROP:
                if (held.size() > 0)
                    void'(held.pop_front());
            fqd_pkg::MODE_DELETE:
            begin
                for (int k = 0; k < held.size(); k++)
                    if (hit < 0 && held[k] == v)
                        hit = k;
                if (hit >= 0)
                begin
                    held.delete(hit);
                    s.fnd = 1'b1;
                end
            end
            fqd_pkg::MODE_CLEAR:
                held.delete();
            default:
                ;
        endcase
        s.hv   = (held.size() > 0);
        s.hval = s.hv ? held[0] : '0;
        s.occ  = CNT_W'(held.size());
        return s;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        queue_status_t want;
        if (!rst_n)
        begin
            held.delete();
            awaited.delete();
            waiting = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited.push_back(apply_op(mode, value));
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none got occupancy %0d",
                             $time, occupancy);
                    fail_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    flag_field("head_valid", want.hv, head_valid);
                    flag_field("head_value", want.hval, head_value);
                    flag_field("occupancy", want.occ, occupancy);
                    flag_field("found", want.fnd, found);
                    flag_field("rejected", want.rej, rejected);
                end
            end
            waiting = awaited.size();
        end
    end

endmodule

FILE: tb/fifo_queue_delete_by_value_test.sv
`timescale 1ns / 1ps
// stimulus and verdict for the delete-by-value queue, with the checker beside the block
module fifo_queue_delete_by_value_test;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_BEATS = 1550;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 2000;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic               head_valid;
    logic signed [31:0] head_value;
    logic [CNT_W-1:0]   occupancy;
    logic               found;
    logic               rejected;
    int                 mismatches;
    int                 pending;

    logic               calm;
    logic               hold_req;
    int                 hold_left;
    logic signed [31:0] recent [DEPTH];
    int                 recent_wr;

    fifo_queue_delete_by_value #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head_valid (head_valid),
        .head_value (head_value),
        .occupancy  (occupancy),
        .found      (found),
        .rejected   (rejected)
    );

    fqd_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head_valid (head_valid),
        .head_value (head_value),
        .occupancy  (occupancy),
        .found      (found),
        .rejected   (rejected),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin : result_side
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 29);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_beat(input logic [2:0] m, input logic signed [31:0] v);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        if (m == fqd_pkg::MODE_APPEND)
        begin
            recent[recent_wr] = v;
            recent_wr = (recent_wr + 1) % DEPTH;
        end
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // deletes mostly aim at values already appended so that matches are common
    function automatic logic signed [31:0] pick_value(input bit for_delete);
        int r;
        r = $urandom_range(0, 99);
        if (for_delete && r < 60)
            return recent[$urandom_range(0, DEPTH - 1)];
        if (r < 70)
            return $signed($urandom);
        if (r < 90)
            return $signed($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    initial
    begin : stimulus
        int         r;
        int         app_w;
        int         drop_w;
        logic [2:0] m;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = fqd_pkg::MODE_PEEK;
        value     = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        recent_wr = 0;
        foreach (recent[k])
            recent[k] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue corners
        send_beat(fqd_pkg::MODE_PEEK, 32'sd0);
        send_beat(fqd_pkg::MODE_DROP, 32'sd0);
        send_beat(fqd_pkg::MODE_DELETE, 32'sd0);
        // extremes and a duplicate, then first-match delete and a miss
        send_beat(fqd_pkg::MODE_APPEND, 32'sh8000_0000);
        send_beat(fqd_pkg::MODE_APPEND, 32'sh7fff_ffff);
        send_beat(fqd_pkg::MODE_APPEND, -32'sd1);
        send_beat(fqd_pkg::MODE_APPEND, 32'sd0);
        send_beat(fqd_pkg::MODE_APPEND, -32'sd1);
        send_beat(fqd_pkg::MODE_DELETE, -32'sd1);
        send_beat(fqd_pkg::MODE_DELETE, 32'sh0000_1234);
        send_beat(MODE_SPARE_LO, 32'sh7fff_ffff);
        send_beat(MODE_SPARE_HI, 32'sh8000_0000);
        send_beat(fqd_pkg::MODE_DROP, 32'sd0);
        // fill to the brim, overflow, delete at tail and head, clear
        for (int k = 0; k < DEPTH - 3; k++)
            send_beat(fqd_pkg::MODE_APPEND, 32'sh5a5a_0000 + k);
        send_beat(fqd_pkg::MODE_APPEND, 32'sh1234_5678);
        send_beat(fqd_pkg::MODE_DELETE, 32'sh5a5a_0000 + DEPTH - 4);
        send_beat(fqd_pkg::MODE_DELETE, 32'sh7fff_ffff);
        send_beat(fqd_pkg::MODE_CLEAR, 32'sd0);
        send_beat(fqd_pkg::MODE_PEEK, 32'sd0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 300)
                hold_req = 1'b1;
            if (n == 500)
            begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            calm = (n >= 800 && n < 1000);
            // alternate filling and draining phases so both full and empty are hit
            if ((n / 120) % 2 == 0)
            begin
                app_w  = 55;
                drop_w = 10;
            end
            else
            begin
                app_w  = 25;
                drop_w = 25;
            end
            r = $urandom_range(0, 99);
            if (r < app_w)
                m = fqd_pkg::MODE_APPEND;
            else if (r < app_w + drop_w)
                m = fqd_pkg::MODE_DROP;
            else if (r < 87)
                m = fqd_pkg::MODE_DELETE;
            else if (r < 93)
                m = fqd_pkg::MODE_PEEK;
            else if (r < 96)
                m = fqd_pkg::MODE_CLEAR;
            else
                m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            send_beat(m, pick_value(m == fqd_pkg::MODE_DELETE));
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
